[rtl/bav_pkg.sv]
// ----------------------------------------------------------------------------
// bav_pkg
// Shared types, constants and the tanh knot table of the bias-add and
// activation unit.
// ----------------------------------------------------------------------------
package bav_pkg;

  // Bias store geometry
  localparam int BIAS_DEPTH = 1024;
  localparam int BIAS_AW    = $clog2(BIAS_DEPTH);
  localparam int LEN_W      = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LEN  = 2'd2;

  // Activation codes; the spare code behaves as no activation
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RELU  = 2'd1;
  localparam logic [1:0] ACT_GELU  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Input word kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_BIAS = 1'b1;

  // GELU fixed-point constants (Q16)
  localparam int GELU_C0      = 52290;
  localparam int GELU_C1      = 2930;
  localparam int A_CLAMP      = 2048;
  localparam int A_W          = 12;
  localparam int ONE_Q16      = 65536;
  localparam int TANH_RANGE_W = 18;
  localparam int GELU_STAGES  = 9;

  // tanh table: TANH_SEGMENTS linear pieces over [0, 4.0)
  localparam int TANH_SEGMENTS = 64;
  localparam int TANH_IDX_W    = $clog2(TANH_SEGMENTS);
  localparam int TANH_FRAC_W   = TANH_RANGE_W - TANH_IDX_W;
  localparam int KNOT_IDX_W    = $clog2(TANH_SEGMENTS + 1);
  localparam int KNOT_W        = 17;

  typedef logic [TANH_SEGMENTS:0][KNOT_W-1:0] knot_tab_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [9:0]         bias_slot;
    logic               final_element;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] activated;
    logic               end_of_tensor;
    logic               size_error;
  } out_word_t;

  // Element traveling along the activation pipeline
  typedef struct packed {
    logic               valid;
    logic               fin;
    logic               err;
    logic signed [16:0] x;
  } tag_t;

  // Truncating unsigned quotient by shift and subtract, table build only
  function automatic longint unsigned div_u64(longint unsigned num,
                                              longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh at knot i in Q16: series at the argument divided by 1024, then ten
  // angle doublings, all in truncating Q30
  function automatic logic [KNOT_W-1:0] tanh_knot(int unsigned i);
    longint unsigned u30;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned x3;
    longint unsigned x5;
    longint unsigned t;
    u30 = (longint'(i) << 32) / TANH_SEGMENTS;
    x   = u30 >> 10;
    x2  = (x * x) >> 30;
    x3  = (x2 * x) >> 30;
    x5  = (x3 * x2) >> 30;
    t   = x - x3 / 3 + (2 * x5) / 15;
    for (int k = 0; k < 10; k++) begin
      t = div_u64(t << 31, (64'd1 << 30) + ((t * t) >> 30));
    end
    return KNOT_W'((t + (64'd1 << 13)) >> 14);
  endfunction

  function automatic knot_tab_t build_tanh_knots();
    knot_tab_t tab;
    for (int i = 0; i <= TANH_SEGMENTS; i++) begin
      tab[i] = tanh_knot(i);
    end
    return tab;
  endfunction

  localparam knot_tab_t TANH_KNOTS = build_tanh_knots();

endpackage

[rtl/bias_add_activation_unit.sv]
// ----------------------------------------------------------------------------
// bias_add_activation_unit
// Streams Q8.8 elements, adds a cycling bias entry and applies no activation,
// ReLU or tanh-approximated GELU, saturating the result to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): a word of kind 1
//   writes sample into the bias store at bias_slot and gives no result; a
//   word of kind 0 is a data element and gives exactly one output word.
//   Output channel (out_valid_o / out_stall_i / out_word_o) carries the
//   activated value, end_of_tensor and size_error (on the final element).
//   Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is to be written only
//   while idle; the block does not enforce this. Throughput: one word per
//   cycle unless out_stall_i holds the output. Each data element passes the
//   registered bias store read, the bias add and the nine-stage GELU pipeline.
//   A bias store write followed by a read of the same entry on the next
//   cycle sees the new value, so no interlock is needed.
//   Reset clears the bias position, the pipeline valid bits and the
//   registers to mode none, bias enabled, length 1. The bias store is not
//   cleared; an entry must be written before it is read.
//   While the output word is held by out_stall_i the whole pipeline holds
//   and in_stall_o is raised.
// ----------------------------------------------------------------------------
module bias_add_activation_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bav_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bav_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [bav_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bav_pkg::CFG_W-1:0]         cfg_wdata_i
);

  // configuration
  logic [1:0]                act_mode_q;
  logic                      bias_en_q;
  logic [bav_pkg::LEN_W-1:0] bias_len_q;

  // bias position
  logic [bav_pkg::BIAS_AW-1:0] pos_q, pos_d, pos_cur;
  logic [bav_pkg::LEN_W-1:0]   eff_len, pos_inc;
  logic                        size_err;

  logic adv, accept, data_acc, bias_wr;

  // stage 1: bias store read in flight
  logic                s1_valid_q;
  logic                s1_fin_q, s1_err_q;
  logic signed [15:0]  s1_sample_q;
  logic [15:0]         bias_rdata;
  logic signed [16:0]  sum_x;

  // stage 2: sum, entering the activation pipeline
  bav_pkg::tag_t       s2_tag_q, s2_tag_d;
  bav_pkg::tag_t       g_tag;
  logic signed [17:0]  gelu_y;

  // output register
  logic                out_valid_q;
  bav_pkg::out_word_t  out_word_q, out_word_d;
  logic signed [17:0]  act_y, x_ext;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign data_acc   = accept && (in_word_i.kind == bav_pkg::KIND_DATA);
  assign bias_wr    = accept && (in_word_i.kind == bav_pkg::KIND_BIAS)
                   && ({1'b0, in_word_i.bias_slot} < bav_pkg::LEN_W'(bav_pkg::BIAS_DEPTH));

  always_comb begin
    // effective length: zero counts as one, clip to the store depth
    if (bias_len_q == '0) begin
      eff_len = bav_pkg::LEN_W'(1);
    end else if (bias_len_q > bav_pkg::LEN_W'(bav_pkg::BIAS_DEPTH)) begin
      eff_len = bav_pkg::LEN_W'(bav_pkg::BIAS_DEPTH);
    end else begin
      eff_len = bias_len_q;
    end
    pos_cur  = (bav_pkg::LEN_W'(pos_q) < eff_len) ? pos_q : '0;
    pos_inc  = bav_pkg::LEN_W'(pos_cur) + 1'b1;
    size_err = in_word_i.final_element && (pos_inc != eff_len);
    pos_d    = (in_word_i.final_element || (pos_inc >= eff_len))
             ? '0 : pos_inc[bav_pkg::BIAS_AW-1:0];
  end

  bav_ram #(
    .WIDTH(16),
    .DEPTH(bav_pkg::BIAS_DEPTH)
  ) u_bias_store (
    .clk_i  (clk_i),
    .we_i   (bias_wr),
    .waddr_i(in_word_i.bias_slot[bav_pkg::BIAS_AW-1:0]),
    .wdata_i(in_word_i.sample),
    .re_i   (data_acc),
    .raddr_i(pos_cur),
    .rdata_o(bias_rdata)
  );

  always_comb begin
    sum_x = 17'(s1_sample_q);
    if (bias_en_q) begin
      sum_x = 17'(s1_sample_q) + 17'($signed(bias_rdata));
    end
    s2_tag_d.valid = s1_valid_q;
    s2_tag_d.fin   = s1_fin_q;
    s2_tag_d.err   = s1_err_q;
    s2_tag_d.x     = sum_x;
  end

  bav_gelu u_gelu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .tag_i (s2_tag_q),
    .tag_o (g_tag),
    .gelu_o(gelu_y)
  );

  always_comb begin
    x_ext = 18'(g_tag.x);
    unique case (act_mode_q)
      bav_pkg::ACT_RELU: act_y = (x_ext > 18'sd0) ? x_ext : 18'sd0;
      bav_pkg::ACT_GELU: act_y = gelu_y;
      default:           act_y = x_ext;
    endcase
    if (act_y > 18'sd32767) begin
      out_word_d.activated = 16'sh7FFF;
    end else if (act_y < -18'sd32768) begin
      out_word_d.activated = 16'sh8000;
    end else begin
      out_word_d.activated = act_y[15:0];
    end
    out_word_d.end_of_tensor = g_tag.fin;
    out_word_d.size_error    = g_tag.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q  <= bav_pkg::ACT_NONE;
      bias_en_q   <= 1'b1;
      bias_len_q  <= bav_pkg::LEN_W'(1);
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bav_pkg::CFG_ACT_MODE: act_mode_q <= cfg_wdata_i[1:0];
          bav_pkg::CFG_BIAS_EN:  bias_en_q  <= cfg_wdata_i[0];
          bav_pkg::CFG_BIAS_LEN: bias_len_q <= cfg_wdata_i[bav_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (data_acc) begin
        pos_q <= pos_d;
      end
      if (adv) begin
        s1_valid_q  <= data_acc;
        s2_tag_q    <= s2_tag_d;
        out_valid_q <= g_tag.valid;
      end
    end
  end

  // payload registers, hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sample_q <= in_word_i.sample;
      s1_fin_q    <= in_word_i.final_element;
      s1_err_q    <= size_err;
      out_word_q  <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/bav_ram.sv]
// ----------------------------------------------------------------------------
// bav_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bav_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bav_gelu.sv]
// ----------------------------------------------------------------------------
// bav_gelu
// Nine-stage GELU pipeline: magnitude clamp, cube, tanh argument, table
// interpolation and the final scaling. The element tag travels alongside.
// ----------------------------------------------------------------------------
module bav_gelu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bav_pkg::tag_t      tag_i,
  output bav_pkg::tag_t      tag_o,
  output logic signed [17:0] gelu_o
);

  bav_pkg::tag_t tag_q [bav_pkg::GELU_STAGES];

  // stage data
  logic [bav_pkg::A_W-1:0] a1_q, a2_q, a3_q, a4_q;
  logic [23:0]             sq2_q;
  logic [35:0]             cube3_q;
  logic [21:0]             cb4_q;
  logic [21:0]             inner5_q;
  logic [21:0]             u6_q;
  logic                    sat7_q;
  logic [bav_pkg::KNOT_W-1:0] y0_7_q, diff7_q, th8_q;
  logic [bav_pkg::TANH_FRAC_W-1:0] frac7_q;
  logic signed [17:0]      y9_q;

  logic [16:0]             abs_x;
  logic [bav_pkg::A_W-1:0] a1_d;
  logic [23:0]             sq2_d;
  logic [35:0]             cube3_d;
  logic [47:0]             c1_prod;
  logic [21:0]             cb4_d;
  logic [21:0]             inner5_d;
  logic [37:0]             c0_prod;
  logic [21:0]             u6_d;
  logic [bav_pkg::TANH_IDX_W-1:0]  idx;
  logic [bav_pkg::KNOT_IDX_W-1:0]  idx_lo, idx_hi;
  logic [bav_pkg::KNOT_W-1:0]      y0, y1, diff7_d, th8_d;
  logic [28:0]             interp;
  logic [17:0]             factor;
  logic signed [35:0]      prod9;
  logic signed [17:0]      y9_d;

  always_comb begin
    // clamp |x| to 8.0
    abs_x = tag_i.x[16] ? 17'(-tag_i.x) : 17'(tag_i.x);
    a1_d  = (abs_x > 17'(bav_pkg::A_CLAMP)) ? bav_pkg::A_W'(bav_pkg::A_CLAMP)
                                             : abs_x[bav_pkg::A_W-1:0];

    sq2_d   = 24'(a1_q) * 24'(a1_q);
    cube3_d = 36'(sq2_q) * 36'(a2_q);

    c1_prod = 48'(bav_pkg::GELU_C1) * 48'(cube3_q) + (48'd1 << 23);
    cb4_d   = 22'(c1_prod >> 24);

    inner5_d = (22'(a4_q) << 8) + cb4_q;

    c0_prod = 38'(bav_pkg::GELU_C0) * 38'(inner5_q) + (38'd1 << 15);
    u6_d    = 22'(c0_prod >> 16);

    // table lookup: segment index and fraction of the Q16 argument
    idx     = u6_q[bav_pkg::TANH_RANGE_W-1:bav_pkg::TANH_FRAC_W];
    idx_lo  = bav_pkg::KNOT_IDX_W'(idx);
    idx_hi  = idx_lo + 1'b1;
    y0      = bav_pkg::TANH_KNOTS[idx_lo];
    y1      = bav_pkg::TANH_KNOTS[idx_hi];
    diff7_d = (y1 > y0) ? (y1 - y0) : '0;

    interp = 29'(diff7_q) * 29'(frac7_q) + 29'(1 << (bav_pkg::TANH_FRAC_W - 1));
    th8_d  = sat7_q ? bav_pkg::KNOT_W'(bav_pkg::ONE_Q16)
                    : y0_7_q + bav_pkg::KNOT_W'(interp >> bav_pkg::TANH_FRAC_W);

    // tanh takes the sign of x
    factor = tag_q[7].x[16] ? (18'(bav_pkg::ONE_Q16) - 18'(th8_q))
                            : (18'(bav_pkg::ONE_Q16) + 18'(th8_q));
    prod9  = 36'(tag_q[7].x) * 36'($signed({1'b0, factor}))
           + 36'sd65536;
    y9_d   = 18'(prod9 >>> 17);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bav_pkg::GELU_STAGES; k++) begin
        tag_q[k] <= '0;
      end
    end else if (adv_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < bav_pkg::GELU_STAGES; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q     <= a1_d;
      a2_q     <= a1_q;
      sq2_q    <= sq2_d;
      a3_q     <= a2_q;
      cube3_q  <= cube3_d;
      a4_q     <= a3_q;
      cb4_q    <= cb4_d;
      inner5_q <= inner5_d;
      u6_q     <= u6_d;
      sat7_q   <= (u6_q[21:bav_pkg::TANH_RANGE_W] != '0);
      y0_7_q   <= y0;
      diff7_q  <= diff7_d;
      frac7_q  <= u6_q[bav_pkg::TANH_FRAC_W-1:0];
      th8_q    <= th8_d;
      y9_q     <= y9_d;
    end
  end

  assign tag_o  = tag_q[bav_pkg::GELU_STAGES-1];
  assign gelu_o = y9_q;

endmodule

[bench/tb_bias_add_activation_unit.sv]
// ----------------------------------------------------------------------------
// tb_bias_add_activation_unit
// Streams bias loads and tensor elements through the unit under random valid
// and stall gaps, predicts every output word from its own copy of the bias
// store, position and registers, and checks the words in order.
// ----------------------------------------------------------------------------
module tb_bias_add_activation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BIAS_SLOTS  = 1024;
  localparam int unsigned TANH_PIECES = 64;
  localparam longint      TANH_SPAN   = 262144;  // 4.0 in Q16
  localparam longint      UNIT_Q16    = 65536;
  localparam longint      GELU_K0     = 52290;
  localparam longint      GELU_K1     = 2930;
  localparam int          SETTLE      = 16;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 40;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  bav_pkg::in_word_t             in_word_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  bav_pkg::out_word_t            out_word_o;
  logic                          cfg_we_i;
  logic [bav_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bav_pkg::CFG_W-1:0]     cfg_wdata_i;

  bias_add_activation_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [15:0]  bias_mem [BIAS_SLOTS];
  int unsigned  bias_pos;
  logic [1:0]   act_mode;
  logic         bias_on;
  logic [10:0]  bias_len;
  longint       tanh_knots [TANH_PIECES+1];

  bav_pkg::in_word_t  element_q [$];
  bav_pkg::out_word_t activated_q [$];
  int           mismatches = 0;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           quiet_cycles = 0;

  // Stimulus-side tracking so that no unwritten bias entry is ever added to an element
  bit           slot_loaded [BIAS_SLOTS];
  int unsigned  gen_pos = 0;

  function automatic longint tanh_knot_q16(int unsigned k);
    longint unsigned arg, z, z2, z3, z5, t;
    arg = (64'(k) << 32) / TANH_PIECES;
    z   = arg >> 10;
    z2  = (z * z) >> 30;
    z3  = (z2 * z) >> 30;
    z5  = (z3 * z2) >> 30;
    t   = z - z3 / 3 + (2 * z5) / 15;
    // double the angle ten times back up to the knot argument
    repeat (10) t = (t << 31) / ((64'd1 << 30) + ((t * t) >> 30));
    return longint'((t + (64'd1 << 13)) >> 14);
  endfunction

  function automatic longint tanh_q16(longint u);
    longint p, seg, rem, y0, y1, rise;
    if (u >= TANH_SPAN) return UNIT_Q16;
    p    = u * TANH_PIECES;
    seg  = p / TANH_SPAN;
    rem  = p % TANH_SPAN;
    y0   = tanh_knots[seg];
    y1   = tanh_knots[seg+1];
    rise = (y1 > y0) ? y1 - y0 : 0;
    return y0 + (rise * rem + TANH_SPAN / 2) / TANH_SPAN;
  endfunction

  function automatic longint gelu_q88(longint x);
    longint a, inner, u, th;
    a = (x < 0) ? -x : x;
    if (a > 2048) a = 2048;
    inner = a * 256 + ((GELU_K1 * a * a * a + (64'd1 << 23)) >> 24);
    u     = (GELU_K0 * inner + (64'd1 << 15)) >> 16;
    th    = tanh_q16(u);
    if (x < 0) th = -th;
    return (x * (UNIT_Q16 + th) + 65536) >>> 17;
  endfunction

  function automatic int unsigned eff_length();
    if (bias_len == 0) return 1;
    if (bias_len > BIAS_SLOTS) return BIAS_SLOTS;
    return bias_len;
  endfunction

  function automatic void predict_activation(bav_pkg::in_word_t w);
    int unsigned        eff, pos;
    longint             x, y;
    bav_pkg::out_word_t r;
    if (w.kind == bav_pkg::KIND_BIAS) begin
      bias_mem[w.bias_slot] = w.sample;
      return;
    end
    eff = eff_length();
    pos = (bias_pos < eff) ? bias_pos : 0;
    x = longint'(signed'(w.sample));
    if (bias_on) x += longint'(signed'(bias_mem[pos]));
    case (act_mode)
      bav_pkg::ACT_RELU: y = (x > 0) ? x : 0;
      bav_pkg::ACT_GELU: y = gelu_q88(x);
      default:           y = x;
    endcase
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.activated     = y[15:0];
    r.end_of_tensor = w.final_element;
    r.size_error    = w.final_element && (pos + 1 != eff);
    bias_pos = (w.final_element || pos + 1 >= eff) ? 0 : pos + 1;
    activated_q.push_back(r);
  endfunction

  // Driver: advance to the next pending word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_activation(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (element_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i  <= element_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    bav_pkg::out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (activated_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, out_word_o);
          mismatches++;
        end else begin
          want = activated_q.pop_front();
          if (out_word_o.activated !== want.activated) begin
            $display("%0t: activated expected %0d got %0d", $time,
                     $signed(want.activated), $signed(out_word_o.activated));
            mismatches++;
          end
          if (out_word_o.end_of_tensor !== want.end_of_tensor) begin
            $display("%0t: end_of_tensor expected %b got %b", $time,
                     want.end_of_tensor, out_word_o.end_of_tensor);
            mismatches++;
          end
          if (out_word_o.size_error !== want.size_error) begin
            $display("%0t: size_error expected %b got %b", $time,
                     want.size_error, out_word_o.size_error);
            mismatches++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] random_q88();
    case ($urandom_range(9))
      0:       return 16'h7fff - 16'($urandom_range(3));
      1:       return 16'h8000 + 16'($urandom_range(3));
      2, 3:    return 16'($urandom());
      default: return 16'(int'($urandom_range(2048)) - 1024);  // within +-4.0
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (element_q.size() != 0 || in_valid_i || activated_q.size() != 0);
  endtask

  task automatic queue_bias(logic [9:0] slot, logic [15:0] value);
    bav_pkg::in_word_t w;
    w.kind          = bav_pkg::KIND_BIAS;
    w.sample        = value;
    w.bias_slot     = slot;
    w.final_element = 1'($urandom_range(1));
    slot_loaded[slot] = 1'b1;
    element_q.push_back(w);
  endtask

  task automatic queue_element(logic [15:0] sample, logic fin);
    bav_pkg::in_word_t w;
    if (gen_pos >= eff_length()) gen_pos = 0;
    if (bias_on && !slot_loaded[gen_pos]) queue_bias(gen_pos[9:0], random_q88());
    w.kind          = bav_pkg::KIND_DATA;
    w.sample        = sample;
    w.bias_slot     = 10'($urandom_range(1023));
    w.final_element = fin;
    element_q.push_back(w);
    gen_pos = (fin || gen_pos + 1 >= eff_length()) ? 0 : gen_pos + 1;
  endtask

  task automatic write_reg(logic [bav_pkg::CFG_IDX_W-1:0] idx,
                           logic [bav_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      bav_pkg::CFG_ACT_MODE: act_mode = value[1:0];
      bav_pkg::CFG_BIAS_EN:  bias_on  = value[0];
      bav_pkg::CFG_BIAS_LEN: bias_len = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [1:0] mode, logic en, logic [10:0] len);
    wait_drained();
    // let the unit sit idle before the configuration is written
    repeat (SETTLE) @(posedge clk_i);
    write_reg(bav_pkg::CFG_ACT_MODE, bav_pkg::CFG_W'(mode));
    write_reg(bav_pkg::CFG_BIAS_EN, bav_pkg::CFG_W'(en));
    write_reg(bav_pkg::CFG_BIAS_LEN, bav_pkg::CFG_W'(len));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [1:0] mode, logic en, logic [10:0] len, int n, bit pause);
    int  left, tlen, eff, kind_roll;
    bit  paused;
    set_config(mode, en, len);
    left   = n;
    paused = 1'b0;
    while (left > 0) begin
      if (pause && !paused && left <= n / 2) begin
        // hold the feed until every pending word is out
        wait_drained();
        paused = 1'b1;
      end
      eff       = eff_length();
      kind_roll = $urandom_range(99);
      if (kind_roll < 70) tlen = (eff <= 16) ? eff * $urandom_range(1, 3) : $urandom_range(1, 30);
      else tlen = $urandom_range(1, 20);
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(99) < 12) queue_bias(10'($urandom_range(1023)), random_q88());
        queue_element(random_q88(), (i == tlen - 1) && ($urandom_range(99) < 95));
      end
      left -= tlen;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    act_mode    = bav_pkg::ACT_NONE;
    bias_on     = 1'b1;
    bias_len    = 11'd1;
    bias_pos    = 0;
    for (int k = 0; k <= TANH_PIECES; k++) tanh_knots[k] = tanh_knot_q16(k);
    send_idle_pct = 6;
    recv_idle_pct = 46;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: saturation at both ends, top slot load
    queue_bias(10'd0, 16'h7fff);
    queue_element(16'h7fff, 1'b1);
    queue_bias(10'd0, 16'h8000);
    queue_element(16'h8000, 1'b1);
    queue_element(16'h0001, 1'b0);
    queue_bias(10'd1023, 16'h5a5a);

    // ReLU, one whole tensor then a short one
    set_config(bav_pkg::ACT_RELU, 1'b1, 11'd3);
    queue_element(16'hfffb, 1'b0);
    queue_element(16'h0005, 1'b0);
    queue_element(16'h0000, 1'b1);
    queue_element(16'hffff, 1'b0);
    queue_element(16'h0100, 1'b1);

    // GELU with the bias off and length zero, across the clamp and the tanh range
    set_config(bav_pkg::ACT_GELU, 1'b0, 11'd0);
    queue_element(16'h7fff, 1'b0);
    queue_element(16'h8000, 1'b0);
    queue_element(16'h0000, 1'b0);
    queue_element(16'h0800, 1'b0);
    queue_element(16'hf800, 1'b0);
    queue_element(16'h0400, 1'b0);
    queue_element(16'hff00, 1'b1);

    // unused mode code, length past the store depth
    set_config(bav_pkg::ACT_SPARE, 1'b0, 11'd2047);
    queue_element(16'h0002, 1'b0);
    queue_element(16'h7ffe, 1'b1);

    // shrink the length mid-tensor so the position falls back to zero
    set_config(bav_pkg::ACT_RELU, 1'b1, 11'd4);
    queue_element(16'h0010, 1'b0);
    queue_element(16'hfff0, 1'b0);
    queue_element(16'h0200, 1'b0);
    set_config(bav_pkg::ACT_GELU, 1'b1, 11'd2);
    queue_element(16'h0180, 1'b1);

    run_phase(bav_pkg::ACT_GELU, 1'b1, 11'd1, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_RELU, 1'b1, 11'd4, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_NONE, 1'b1, 11'd7, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_GELU, 1'b1, 11'd16, PHASE_ITEMS, 1'b0);

    send_idle_pct = 46;
    recv_idle_pct = 6;
    run_phase(bav_pkg::ACT_GELU, 1'b0, 11'd5, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_SPARE, 1'b1, 11'd3, PHASE_ITEMS, 1'b1);
    run_phase(bav_pkg::ACT_RELU, 1'b1, 11'd1024, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_GELU, 1'b1, 11'd2, PHASE_ITEMS, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(bav_pkg::ACT_NONE, 1'b0, 11'd2047, PHASE_ITEMS, 1'b0);
    run_phase(bav_pkg::ACT_GELU, 1'b1, 11'd0, PHASE_ITEMS, 1'b0);
    run_phase(2'($urandom_range(3)), 1'($urandom_range(1)), 11'($urandom_range(1, 12)),
              PHASE_ITEMS, 1'b0);
    run_phase(2'($urandom_range(3)), 1'($urandom_range(1)), 11'($urandom_range(2047)),
              PHASE_ITEMS, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && activated_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
